FILE: src/shrd_pkg.sv
// Shared types and constants for the smoothed hysteresis region detector.
`timescale 1ns / 1ps
`default_nettype none

package shrd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int THR_W       = 16;
   localparam int WIDTH_W     = 17;
   localparam int IDX_W       = 16;
   localparam int CSR_DATA_W  = 17;
   localparam int MAX_LEN_DEF = 65536;
   localparam int Q_DEPTH     = 2;

   localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = 17'd1;
   localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = 17'h10000;

   typedef enum logic [1:0] {
      CSR_HIGH_THR  = 2'd0,
      CSR_LOW_THR   = 2'd1,
      CSR_MIN_WIDTH = 2'd2,
      CSR_MAX_WIDTH = 2'd3
   } csr_addr_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] start_index;
      logic [IDX_W-1:0] end_index;
      logic             final_report;
   } rsp_type;

   typedef struct packed {
      logic signed [THR_W-1:0] high_thr;
      logic signed [THR_W-1:0] low_thr;
      logic [WIDTH_W-1:0]      min_width;
      logic [WIDTH_W-1:0]      max_width;
   } cfg_type;

   // Up to two reports produced by one sample, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
   } pair_type;

endpackage

`default_nettype wire

FILE: src/smoothed_hysteresis_region_detector_core.sv
// Top level of the smoothed hysteresis region detector.
// The input register holds an accepted sample beat until the result queue has space for
// a full pair; its reports are then registered in the queue, which drives rsp_valid.
// Throughput: one sample per cycle while the result queue has space; a sample
// that closes two regions needs two rsp beats, and the two-pair result queue
// absorbs such bursts. Reset (synchronous, active high) clears the stream state
// and the queue and returns the thresholds to zero, min_width to 1 and max_width to 65536.
`timescale 1ns / 1ps
`default_nettype none

module smoothed_hysteresis_region_detector_core import shrd_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire csr_addr_type           csr_addr,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers. User writes them only while idle; the block does not check.
   cfg_type  cfg_ff, cfg_in;

   // Input register: one sample beat waiting for the tracking logic.
   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;

   logic     accept;
   logic     fire;
   logic     space;
   pair_type pair;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_addr)
            CSR_HIGH_THR:  cfg_in.high_thr  = csr_wdata[THR_W-1:0];
            CSR_LOW_THR:   cfg_in.low_thr   = csr_wdata[THR_W-1:0];
            CSR_MIN_WIDTH: cfg_in.min_width = csr_wdata[WIDTH_W-1:0];
            CSR_MAX_WIDTH: cfg_in.max_width = csr_wdata[WIDTH_W-1:0];
         endcase
      end
   end

   // The held sample moves on whenever the result queue can take a full pair,
   // so a new beat is taken in the same cycle the held one is processed.
   assign fire      = in_valid_ff && space;
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_thr  <= '0;
         cfg_ff.low_thr   <= '0;
         cfg_ff.min_width <= MIN_WIDTH_RST;
         cfg_ff.max_width <= MAX_WIDTH_RST;
         in_valid_ff      <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_payload;
      end
   end

   // Smoothing and run tracking: all stream state lives here and advances once
   // per processed sample.
   shrd_track #(
      .MAX_LEN (MAX_LEN)
   ) u_track (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_data_ff),
      .cfg   (cfg_ff),
      .pair  (pair)
   );

   // Samples that produce no report leave nothing in the queue.
   shrd_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (fire && (pair.count != 2'd0)),
      .push_pair   (pair),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: src/shrd_track.sv
// Smoothing, threshold compare and run tracking for one sample per cycle while fire is high.
`timescale 1ns / 1ps
`default_nettype none

module shrd_track import shrd_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     fire,
   input  wire req_type  item,
   input  wire cfg_type  cfg,
   output pair_type      pair
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int SUM_W = SAMPLE_BITS + 2;
   localparam int CMP_W = (CNT_W > WIDTH_W) ? CNT_W : WIDTH_W;

   typedef struct packed {
      logic             open;
      logic             qual;
      logic [CNT_W-1:0] start;
   } run_type;

   typedef struct packed {
      run_type          run;
      logic             emit;
      logic [CNT_W-1:0] e_start;
      logic [CNT_W-1:0] e_end;
   } proc_type;

   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_BITS-1:0] prev2_ff, prev2_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   run_type                       run_ff, run_in;

   function automatic logic signed [SUM_W-1:0] sext_s(input logic signed [SAMPLE_BITS-1:0] v);
      return {{(SUM_W-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
   endfunction

   // Threshold times the tap count, so the average is never divided out.
   function automatic logic signed [SUM_W-1:0] scaled(input logic signed [THR_W-1:0] t,
                                                      input logic [1:0] taps);
      logic signed [SUM_W-1:0] te;
      te = {{(SUM_W-THR_W){t[THR_W-1]}}, t};
      if (taps == 2'd1) begin
         return te;
      end else if (taps == 2'd2) begin
         return te <<< 1;
      end else begin
         return te + (te <<< 1);
      end
   endfunction

   function automatic proc_type process(input run_type st, input logic [CNT_W-1:0] idx,
                                        input logic signed [SUM_W-1:0] sum,
                                        input logic [1:0] taps, input cfg_type c);
      proc_type                r;
      logic signed [THR_W-1:0] low_eff;
      logic                    above_low;
      logic                    above_high;
      low_eff    = (c.low_thr < c.high_thr) ? c.low_thr : c.high_thr;
      above_low  = sum > scaled(low_eff, taps);
      above_high = sum > scaled(c.high_thr, taps);
      r.run     = st;
      r.emit    = 1'b0;
      r.e_start = st.start;
      r.e_end   = idx - CNT_W'(1);
      if (above_low) begin
         if (!st.open) begin
            r.run.open  = 1'b1;
            r.run.start = idx;
            r.run.qual  = 1'b0;
         end
         if (above_high) begin
            r.run.qual = 1'b1;
         end
      end else if (st.open) begin
         r.emit     = st.qual;
         r.run.open = 1'b0;
         r.run.qual = 1'b0;
      end
      return r;
   endfunction

   function automatic logic width_ok(input logic [CNT_W-1:0] s, input logic [CNT_W-1:0] e,
                                     input cfg_type c);
      logic [CNT_W-1:0] w;
      logic [CMP_W-1:0] we;
      w  = e - s + CNT_W'(1);
      we = CMP_W'(w);
      return (we >= CMP_W'(c.min_width)) && (we <= CMP_W'(c.max_width));
   endfunction

   // Step A: the new sample completes the smoothed value one index back.
   // Step B: the last flag completes the final index and closes the set.
   always_comb begin
      logic                          kept;
      logic signed [SUM_W-1:0]       x_e;
      proc_type                      pa;
      proc_type                      pb;
      run_type                       run_a;
      logic [CNT_W-1:0]              c;
      logic signed [SAMPLE_BITS-1:0] p_a;
      logic signed [SAMPLE_BITS-1:0] pp_a;
      logic                          e1;
      logic                          e2;
      logic [CNT_W-1:0]              b_start;
      logic [CNT_W-1:0]              b_end;

      kept  = count_ff < CNT_W'(MAX_LEN);
      x_e   = sext_s(item.sample);
      pa    = '0;
      pb    = '0;
      run_a = run_ff;
      c     = count_ff;
      p_a   = prev_ff;
      pp_a  = prev2_ff;

      if (kept) begin
         if (count_ff >= CNT_W'(2)) begin
            pa = process(run_ff, count_ff - CNT_W'(1),
                         sext_s(prev2_ff) + sext_s(prev_ff) + x_e, 2'd3, cfg);
            run_a = pa.run;
         end else if (count_ff == CNT_W'(1)) begin
            pa = process(run_ff, '0, sext_s(prev_ff) + x_e, 2'd2, cfg);
            run_a = pa.run;
         end
         pp_a = prev_ff;
         p_a  = item.sample;
         c    = count_ff + CNT_W'(1);
      end

      e1      = pa.emit && width_ok(pa.e_start, pa.e_end, cfg);
      e2      = 1'b0;
      b_start = '0;
      b_end   = '0;

      prev_in  = p_a;
      prev2_in = pp_a;
      count_in = c;
      run_in   = run_a;

      if (item.last_sample) begin
         if (c >= CNT_W'(2)) begin
            pb = process(run_a, c - CNT_W'(1), sext_s(pp_a) + sext_s(p_a), 2'd2, cfg);
         end else if (c == CNT_W'(1)) begin
            pb = process(run_a, '0, sext_s(p_a), 2'd1, cfg);
         end else begin
            pb.run = run_a;
         end
         if (pb.emit) begin
            b_start = pb.e_start;
            b_end   = pb.e_end;
            e2      = width_ok(b_start, b_end, cfg);
         end else if ((c != '0) && pb.run.open && pb.run.qual) begin
            // A run still open at the end of the set closes at the last index.
            b_start = pb.run.start;
            b_end   = c - CNT_W'(1);
            e2      = width_ok(b_start, b_end, cfg);
         end
         prev_in  = '0;
         prev2_in = '0;
         count_in = '0;
         run_in   = '0;
      end

      pair = '0;
      if (e1) begin
         pair.r0.start_index  = IDX_W'(pa.e_start);
         pair.r0.end_index    = IDX_W'(pa.e_end);
         pair.r0.final_report = !e2;
         pair.r1.start_index  = IDX_W'(b_start);
         pair.r1.end_index    = IDX_W'(b_end);
         pair.r1.final_report = 1'b1;
         pair.count           = e2 ? 2'd2 : 2'd1;
      end else if (e2) begin
         pair.r0.start_index  = IDX_W'(b_start);
         pair.r0.end_index    = IDX_W'(b_end);
         pair.r0.final_report = 1'b1;
         pair.count           = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         prev2_ff <= '0;
         count_ff <= '0;
         run_ff   <= '0;
      end else if (fire) begin
         prev_ff  <= prev_in;
         prev2_ff <= prev2_in;
         count_ff <= count_in;
         run_ff   <= run_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/shrd_rsp_queue.sv
// Result queue holding report pairs and sending them out one beat at a time.
`timescale 1ns / 1ps
`default_nettype none

module shrd_rsp_queue import shrd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire pair_type push_pair,
   output logic          space,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_payload
);

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   pair_type         slot_ff [Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             sub_ff, sub_in;
   logic             pop;
   logic             pop_entry;
   pair_type         head;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign head        = slot_ff[rd_ptr_ff];
   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = sub_ff ? head.r1 : head.r0;
   assign pop         = rsp_valid && !rsp_stall;
   assign pop_entry   = pop && rsp_payload.final_report;
   assign space       = (count_ff < CNT_W'(Q_DEPTH)) || pop_entry;

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_entry ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop_entry) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && pop_entry) begin
         count_in = count_ff - CNT_W'(1);
      end
      sub_in = pop_entry ? 1'b0 : (pop ? 1'b1 : sub_ff);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

endmodule

`default_nettype wire
